// ===== hw/rtl/mbsf_pkg.sv =====
// Shared constants, register indexes and request types of the mirror-border FIR row filter.
`default_nettype none

package mbsf_pkg;

    localparam int MAX_TAPS  = 16;
    localparam int MAX_ROW   = 4096;
    localparam int WIN_DEPTH = 31;
    localparam int MAX_OUT   = 16;

    localparam int POS_W    = $clog2(MAX_ROW) + 1;
    localparam int J_W      = POS_W + 2;
    localparam int TAP_W    = 5;
    localparam int K_W      = $clog2(MAX_TAPS);
    localparam int WA_W     = $clog2(WIN_DEPTH);
    localparam int CNT_W    = $clog2(MAX_OUT + 1);
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PAIR_W   = SAMPLE_W + 1;
    localparam int PROD_W   = PAIR_W + COEF_W;
    localparam int ACC_W    = 37;
    localparam int GROUP_W  = 64;
    localparam int GROUPS   = 4;
    localparam int ADDR_W   = 6;
    localparam int RIDX_W   = 3;

    localparam logic [RIDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [RIDX_W-1:0] REG_ODD_MODE  = 3'd1;
    localparam logic [RIDX_W-1:0] REG_COEF_A    = 3'd2;
    localparam logic [RIDX_W-1:0] REG_COEF_B    = 3'd3;
    localparam logic [RIDX_W-1:0] REG_COEF_C    = 3'd4;
    localparam logic [RIDX_W-1:0] REG_COEF_D    = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       row_end;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] filtered;
        logic                    row_done;
        logic                    short_row;
    } t_out;

endpackage

`default_nettype wire

// ===== hw/rtl/mirror_border_symmetric_fir_row.sv =====
// Streaming symmetric/antisymmetric FIR over one image row with mirror borders.
//
// One sample request is taken per idle cycle; the block then stays busy while a single
// shared 16x17 multiply-accumulate walks the tap pairs of each result that the sample
// releases. A result issues tap_count tap pairs (held to 2..16), then drains the MAC
// pipeline and loads the output register; the row-end sample flushes up to 16 results.
// The 31-entry sample window has two read ports and one write port; a finished result
// sits in an output register, so the next sample is taken while it waits.
`default_nettype none

module mirror_border_symmetric_fir_row
    import mbsf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_valid,
    input  wire t_in                 i_data,
    output logic                     o_stall,

    output logic                     o_valid,
    output t_out                     o_data,
    input  wire logic                i_stall,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [GROUP_W-1:0]  pwdata,
    output logic [GROUP_W-1:0]       prdata,
    output logic                     pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    // configuration
    logic [TAP_W-1:0]   r_tap_count;
    logic               r_odd_mode;
    logic [GROUP_W-1:0] r_coef [GROUPS];

    // row bookkeeping
    logic [POS_W-1:0] r_row_pos;
    logic [POS_W-1:0] r_emit;
    logic [WA_W-1:0]  r_wptr;

    // job of the current request
    logic [1:0]       r_state;
    logic [POS_W-1:0] r_p;
    logic [WA_W-1:0]  r_jp;
    logic [POS_W-1:0] r_n;
    logic [POS_W-1:0] r_i;
    logic [CNT_W-1:0] r_left;
    logic [K_W-1:0]   r_k;
    logic             r_job_end;
    logic             r_short;

    // window memory and MAC pipeline
    logic [SAMPLE_W-1:0]      r_win [WIN_DEPTH];
    logic [SAMPLE_W-1:0]      r_rd_r;
    logic [SAMPLE_W-1:0]      r_rd_l;
    logic                     r_s1_v;
    logic                     r_s1_first;
    logic                     r_s1_last;
    logic [K_W-1:0]           r_s1_k;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s2_v;
    logic                     r_s2_first;
    logic                     r_s2_last;
    logic signed [ACC_W-1:0]  r_acc;

    logic r_out_v;
    t_out r_out;

    // helpers
    logic                     cfg_wr;
    logic [RIDX_W-1:0]        cfg_idx;
    logic                     in_acc;
    logic                     out_load;
    logic [TAP_W-1:0]         taps;
    logic [K_W-1:0]           last_k;
    logic [POS_W-1:0]         row_n;
    logic                     end_flag;
    logic                     short_flag;
    logic signed [J_W-1:0]    avail;
    logic [CNT_W-1:0]         cnt_ne;
    logic [POS_W-1:0]         e_clip;
    logic [POS_W-1:0]         e_start;
    logic [CNT_W-1:0]         cnt_end;
    logic [WA_W-1:0]          n_wptr;
    logic signed [J_W-1:0]    j_right;
    logic signed [J_W-1:0]    j_left;
    logic [WA_W-1:0]          addr_r;
    logic [WA_W-1:0]          addr_l;
    logic signed [COEF_W-1:0] coef;
    logic signed [PAIR_W-1:0] pair;
    logic signed [PAIR_W-1:0] samp_r;
    logic signed [PAIR_W-1:0] samp_l;

    // Reflect a row index into [0, n-1] without repeating the edge pixel.
    function automatic logic [POS_W-1:0] f_mirror(input logic signed [J_W-1:0] j_in,
                                                 input logic [POS_W-1:0] n);
        logic signed [J_W-1:0] j;
        logic signed [J_W-1:0] last;
        j    = j_in;
        last = J_W'($signed({2'b00, n}) - 1);
        if (j < 0) begin
            j = -j;
        end
        if (j > last) begin
            j = J_W'(last + last - j);
        end
        if (j < 0) begin
            j = '0;
        end
        if (j > last) begin
            j = last;
        end
        return j[POS_W-1:0];
    endfunction

    // Window slot of row index j, counted back from the slot of the newest sample.
    function automatic logic [WA_W-1:0] f_slot(input logic [POS_W-1:0] j,
                                              input logic [POS_W-1:0] p,
                                              input logic [WA_W-1:0]  jp);
        logic [POS_W-1:0] d;
        logic [WA_W-1:0]  d5;
        d  = p - j;
        d5 = d[WA_W-1:0];
        if (jp >= d5) begin
            return WA_W'(jp - d5);
        end
        return WA_W'(32'(jp) + WIN_DEPTH - 32'(d5));
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[ADDR_W-1:3];
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == S_PUSH) && (!r_out_v || !i_stall);
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    always_comb begin
        case (cfg_idx)
            REG_TAP_COUNT: prdata = GROUP_W'(r_tap_count);
            REG_ODD_MODE:  prdata = GROUP_W'(r_odd_mode);
            REG_COEF_A:    prdata = r_coef[0];
            REG_COEF_B:    prdata = r_coef[1];
            REG_COEF_C:    prdata = r_coef[2];
            REG_COEF_D:    prdata = r_coef[3];
            default:       prdata = '0;
        endcase
    end

    // plan of the request: how many results it releases and from which pixel
    always_comb begin
        if (r_tap_count < TAP_W'(2)) begin
            taps = TAP_W'(2);
        end else if (r_tap_count > TAP_W'(MAX_TAPS)) begin
            taps = TAP_W'(MAX_TAPS);
        end else begin
            taps = r_tap_count;
        end
        last_k     = K_W'(taps - TAP_W'(1));
        row_n      = r_row_pos + POS_W'(1);
        end_flag   = i_data.row_end || (32'(row_n) >= MAX_ROW);
        short_flag = (row_n < POS_W'(taps));

        avail = J_W'($signed({2'b00, r_row_pos}) - $signed(J_W'(last_k))
                     - $signed({2'b00, r_emit}));
        if (avail < 0) begin
            cnt_ne = '0;
        end else if (avail >= J_W'(MAX_OUT - 1)) begin
            cnt_ne = CNT_W'(MAX_OUT);
        end else begin
            cnt_ne = CNT_W'(avail + J_W'(1));
        end

        e_clip  = (r_emit > row_n - POS_W'(1)) ? row_n - POS_W'(1) : r_emit;
        e_start = (row_n - e_clip > POS_W'(MAX_OUT)) ? row_n - POS_W'(MAX_OUT) : e_clip;
        cnt_end = CNT_W'(row_n - e_start);

        n_wptr = (r_wptr == WA_W'(WIN_DEPTH - 1)) ? '0 : r_wptr + WA_W'(1);
    end

    // tap issue: mirrored indexes and window slots
    always_comb begin
        j_right = $signed({2'b00, r_i}) + $signed(J_W'(r_k));
        j_left  = $signed({2'b00, r_i}) - $signed(J_W'(r_k));
        addr_r  = f_slot(f_mirror(j_right, r_n), r_p, r_jp);
        addr_l  = f_slot(f_mirror(j_left, r_n), r_p, r_jp);
    end

    // pair and coefficient of the tap in stage one
    always_comb begin
        coef   = $signed(r_coef[r_s1_k[K_W-1:2]][16*r_s1_k[1:0] +: COEF_W]);
        samp_r = PAIR_W'($signed(r_rd_r));
        samp_l = PAIR_W'($signed(r_rd_l));
        if (r_s1_first) begin
            pair = samp_r;
        end else if (r_odd_mode) begin
            pair = samp_r - samp_l;
        end else begin
            pair = samp_r + samp_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_W'(2);
            r_odd_mode  <= 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                r_coef[g] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TAP_COUNT: r_tap_count <= pwdata[TAP_W-1:0];
                REG_ODD_MODE:  r_odd_mode  <= pwdata[0];
                REG_COEF_A:    r_coef[0]   <= pwdata;
                REG_COEF_B:    r_coef[1]   <= pwdata;
                REG_COEF_C:    r_coef[2]   <= pwdata;
                REG_COEF_D:    r_coef[3]   <= pwdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win[r_wptr] <= i_data.sample;
        end
        r_rd_r <= r_win[addr_r];
        r_rd_l <= r_win[addr_l];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_pos <= '0;
            r_emit    <= '0;
            r_wptr    <= '0;
            r_left    <= '0;
            r_k       <= '0;
            r_job_end <= 1'b0;
            r_short   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_p     <= r_row_pos;
                        r_jp    <= r_wptr;
                        r_n     <= row_n;
                        r_k     <= '0;
                        r_short <= 1'b0;
                        if (end_flag) begin
                            r_row_pos <= '0;
                            r_emit    <= '0;
                            r_wptr    <= '0;
                            r_job_end <= 1'b1;
                            if (short_flag) begin
                                r_short <= 1'b1;
                                r_left  <= CNT_W'(1);
                                r_state <= S_PUSH;
                            end else begin
                                r_i     <= e_start;
                                r_left  <= cnt_end;
                                r_state <= S_RUN;
                            end
                        end else begin
                            r_row_pos <= row_n;
                            r_wptr    <= n_wptr;
                            r_emit    <= r_emit + POS_W'(cnt_ne);
                            r_job_end <= 1'b0;
                            r_i       <= r_emit;
                            r_left    <= cnt_ne;
                            if (cnt_ne != '0) begin
                                r_state <= S_RUN;
                            end
                        end
                    end
                end
                S_RUN: begin
                    if (r_k == last_k) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + K_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_s2_v && r_s2_last) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_load) begin
                        if (r_left == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_left  <= r_left - CNT_W'(1);
                            r_i     <= r_i + POS_W'(1);
                            r_k     <= '0;
                            r_state <= S_RUN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == S_RUN);
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == last_k);
        r_s1_k     <= r_k;
        r_prod     <= PROD_W'(coef * pair);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s2_v) begin
            r_acc <= r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.filtered  <= r_short ? '0 : r_acc;
            r_out.row_done  <= r_short || (r_job_end && (r_left == CNT_W'(1)));
            r_out.short_row <= r_short;
        end
    end

`ifndef SYNTHESIS
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(MAX_OUT))
        else $error("result count exceeds burst limit");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_v && !r_s2_v))
        else $error("MAC pipeline busy while idle");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= last_k))
        else $error("tap counter past last tap");

    a_short_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.short_row) |-> (o_data.row_done && (o_data.filtered == '0)))
        else $error("short-row result malformed");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && r_s2_v && r_s2_last) |=> (r_state == S_PUSH))
        else $error("finished sum not pushed");
`endif

endmodule

`default_nettype wire
